@@ design/stsr_pkg.sv @@
package stsr_pkg;

    // Fixed field widths of the stream words and the configuration register
    localparam int TIME_W   = 16;
    localparam int COUNT_W  = 7;
    localparam int WINDOW_W = 8;
    localparam int STATUS_W = 2;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd3;

    // Defaults for the top-level parameters
    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_TIME_BITS = 16;

    typedef enum logic [0:0] {
        CMD_RESERVE = 1'b0,
        CMD_COUNT   = 1'b1
    } stsr_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_CONFLICT = 2'd1,
        STATUS_FULL     = 2'd2
    } stsr_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } stsr_state_t;

endpackage

@@ design/spaced_time_slot_reserver.sv @@
// A word is accepted in idle; the scan then reads the stored times (at most CAPACITY)
//   out of the slot memory and folds each one in, and commit posts the result once the
//   output register is free, so a stalled output holds commit and adds its wait. A new
//   word is taken only back in idle, after commit; the slot memory read port scans one
//   stored time per cycle.
// Reset (aresetn low, synchronous): empty table, spacing_window = 3, no result pending.
//   The slot memory itself is not cleared; the fill count marks which slots are valid.
module spaced_time_slot_reserver #(
    parameter int CAPACITY  = stsr_pkg::DEF_CAPACITY,
    parameter int TIME_BITS = stsr_pkg::DEF_TIME_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Configuration: spacing_window
    input  logic                          cfg_we,
    input  logic [stsr_pkg::WINDOW_W-1:0] cfg_wdata,

    // Request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [stsr_pkg::TIME_W-1:0]   s_axis_tdata,   // [15:0] time_value
    input  logic                          s_axis_tuser,   // [0] command

    // Result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [6:0] count, [7] zero
    output logic [stsr_pkg::STATUS_W-1:0] m_axis_tuser    // [1:0] status
);

    // Slots are only ever appended, never freed, so the valid slots always form
    // the prefix [0, fill). The fill count stands in for per-slot valid bits.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    stsr_pkg::stsr_state_t  state_reg, state_next;
    stsr_pkg::stsr_cmd_t    cmd_reg, cmd_next;
    logic [TIME_BITS-1:0]   time_reg, time_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic                   hit_reg, hit_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [stsr_pkg::WINDOW_W-1:0] window_reg, window_next;

    logic                   m_valid_reg, m_valid_next;
    stsr_pkg::stsr_status_t m_status_reg, m_status_next;
    logic [stsr_pkg::COUNT_W-1:0] m_count_reg, m_count_next;

    // RAM port signals
    logic                   ram_we;
    logic                   ram_re;
    logic [TIME_BITS-1:0]   ram_rdata;

    // Time input masked (or zero-extended) to TIME_BITS
    logic [stsr_pkg::TIME_W+TIME_BITS-1:0] time_in_wide;
    logic [TIME_BITS-1:0]   time_in;

    // Count truncated or zero-extended to the 7-bit result field
    logic [CW+stsr_pkg::COUNT_W-1:0] cnt_wide;
    logic [stsr_pkg::COUNT_W-1:0]    cnt_field;

    // Compare path against the slot that came out of the RAM this cycle
    logic [TIME_BITS-1:0]   win_ext;
    logic [TIME_BITS-1:0]   diff;
    logic                   near;
    logic                   at_or_below;
    logic                   out_free;

    assign time_in_wide = {{TIME_BITS{1'b0}}, s_axis_tdata};
    assign time_in      = time_in_wide[TIME_BITS-1:0];
    assign cnt_wide     = {{stsr_pkg::COUNT_W{1'b0}}, cnt_reg};
    assign cnt_field    = cnt_wide[stsr_pkg::COUNT_W-1:0];

    assign win_ext     = TIME_BITS'(window_reg);
    assign diff        = (ram_rdata >= time_reg) ? (ram_rdata - time_reg)
                                                 : (time_reg - ram_rdata);
    assign near        = (diff < win_ext);
    assign at_or_below = (ram_rdata <= time_reg);
    assign out_free    = !m_valid_reg || m_axis_tready;

    stsr_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (CAPACITY)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (time_reg),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stsr_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = stsr_pkg::ST_SCAN;
                end
            end
            stsr_pkg::ST_SCAN: begin
                // Leave once every slot was issued and the last read was folded in
                if (idx_reg == fill_reg && !pend_reg) begin
                    state_next = stsr_pkg::ST_COMMIT;
                end
            end
            stsr_pkg::ST_COMMIT: begin
                if (out_free) begin
                    state_next = stsr_pkg::ST_IDLE;
                end
            end
            default: state_next = stsr_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        cmd_next      = cmd_reg;
        time_next     = time_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        hit_next      = hit_reg;
        cnt_next      = cnt_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        window_next   = cfg_we ? cfg_wdata : window_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        unique case (state_reg)
            stsr_pkg::ST_IDLE: begin
                // Latch the request and restart the scan
                if (s_axis_tvalid) begin
                    cmd_next  = stsr_pkg::stsr_cmd_t'(s_axis_tuser);
                    time_next = time_in;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    hit_next  = 1'b0;
                    cnt_next  = '0;
                end
            end
            stsr_pkg::ST_SCAN: begin
                // Issue one slot read per cycle
                pend_next = 1'b0;
                if (idx_reg < fill_reg) begin
                    ram_re    = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                // Fold in the slot read last cycle
                if (pend_reg) begin
                    if (near) begin
                        hit_next = 1'b1;
                    end
                    if (at_or_below) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            stsr_pkg::ST_COMMIT: begin
                // Hold until the output register is free, then post the result
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_count_next = '0;
                    if (cmd_reg == stsr_pkg::CMD_COUNT) begin
                        m_status_next = stsr_pkg::STATUS_OK;
                        m_count_next  = cnt_field;
                    end else if (hit_reg) begin
                        m_status_next = stsr_pkg::STATUS_CONFLICT;
                    end else if (fill_reg == CW'(CAPACITY)) begin
                        m_status_next = stsr_pkg::STATUS_FULL;
                    end else begin
                        // Append into the first free slot
                        m_status_next = stsr_pkg::STATUS_OK;
                        ram_we        = 1'b1;
                        fill_next     = fill_reg + 1'b1;
                    end
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stsr_pkg::ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            window_reg  <= stsr_pkg::WINDOW_RESET;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            window_reg  <= window_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        time_reg     <= time_next;
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        cnt_reg      <= cnt_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign s_axis_tready = (state_reg == stsr_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_count_reg};
    assign m_axis_tuser  = m_status_reg;

    // The table never grows past its capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // A slot is written only while committing into a non-full table
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == stsr_pkg::ST_COMMIT) && (fill_reg < CW'(CAPACITY)))
        else $error("slot write outside commit or into full table");

    // Every slot write advances the fill count by exactly one
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> fill_reg == CW'($past(fill_reg) + 1'b1))
        else $error("fill count did not follow slot write");

    // A count result never exceeds the number of stored times
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stsr_pkg::ST_COMMIT) |-> cnt_reg <= fill_reg)
        else $error("count above fill");

    // A new result appears only out of the commit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == stsr_pkg::ST_COMMIT))
        else $error("result posted outside commit");

endmodule

@@ design/stsr_ram.sv @@
module stsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ test/tb_spaced_time_slot_reserver.sv @@
module tb_spaced_time_slot_reserver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS           = stsr_pkg::DEF_CAPACITY;
    localparam int HOLD_OFF_CYCLES = 300;    // long receiver stall in the back-pressure test
    localparam int WATCHDOG_LIMIT  = 3000;   // cycles with no handshake on either side
    localparam int SETTLE_CYCLES   = 4;      // quiet time before a register write
    localparam int DRAIN_CYCLES    = SLOTS + 8;
    localparam int MAX_REPORTS     = 10;

    typedef logic [stsr_pkg::TIME_W-1:0]   time_word_t;
    typedef logic [stsr_pkg::WINDOW_W-1:0] window_word_t;

    // One result word as the block should produce it
    typedef struct packed {
        stsr_pkg::stsr_status_t         status;
        logic [stsr_pkg::COUNT_W-1:0]   count;
    } slot_answer_t;

    logic                            aclk;
    logic                            aresetn       = 1'b0;
    logic                            cfg_we        = 1'b0;
    logic [stsr_pkg::WINDOW_W-1:0]   cfg_wdata     = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [stsr_pkg::TIME_W-1:0]     s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [7:0]                      m_axis_tdata;
    logic [stsr_pkg::STATUS_W-1:0]   m_axis_tuser;

    // Predictor state: times that are booked, in no particular order, and the window
    time_word_t            booked_times[$];
    window_word_t          window_model = stsr_pkg::WINDOW_RESET;
    slot_answer_t          pending_answers[$];

    int                    mismatches     = 0;
    int                    send_gap_pct   = 0;
    int                    recv_stall_pct = 0;
    int                    hold_off_ticket = 0;

    spaced_time_slot_reserver #(
        .CAPACITY (SLOTS),
        .TIME_BITS(stsr_pkg::DEF_TIME_BITS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),     // [15:0] time_value
        .s_axis_tuser (s_axis_tuser),     // [0] command
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),     // [6:0] count, [7] zero
        .m_axis_tuser (m_axis_tuser)      // [1:0] status
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction: scan every booked time, like the block does, and queue
    // the answer for the word just accepted.
    // ------------------------------------------------------------------
    task automatic forecast_answer(stsr_pkg::stsr_cmd_t cmd, time_word_t t);
        slot_answer_t        ans;
        time_word_t          gap;
        bit                  clash;
        int                  at_or_below;
        ans.status  = stsr_pkg::STATUS_OK;
        ans.count   = '0;
        clash       = 1'b0;
        at_or_below = 0;
        if (cmd == stsr_pkg::CMD_RESERVE) begin
            foreach (booked_times[i]) begin
                gap = (booked_times[i] >= t) ? booked_times[i] - t : t - booked_times[i];
                if (gap < time_word_t'(window_model))
                    clash = 1'b1;
            end
            // conflict wins over a full table
            if (clash)
                ans.status = stsr_pkg::STATUS_CONFLICT;
            else if (booked_times.size() >= SLOTS)
                ans.status = stsr_pkg::STATUS_FULL;
            else
                booked_times.push_back(t);
        end else begin
            foreach (booked_times[i])
                if (booked_times[i] <= t)
                    at_or_below++;
            ans.count = at_or_below[stsr_pkg::COUNT_W-1:0];
        end
        pending_answers.push_back(ans);
    endtask

    // Pick a time: often around a booked time so the window edges get hit,
    // some at the ends of the range, the rest anywhere.
    function automatic time_word_t pick_time();
        int unsigned roll;
        int          span;
        int          offset;
        roll = $urandom_range(99);
        if (roll < 45 && booked_times.size() != 0) begin
            span   = int'(window_model) + 1;
            offset = int'($urandom_range(2 * span)) - span;
            return booked_times[$urandom_range(booked_times.size() - 1)]
                   + time_word_t'(offset);
        end
        if (roll < 55) begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return time_word_t'(1);
                2:       return '1 - time_word_t'(1);
                default: return '1;
            endcase
        end
        return time_word_t'($urandom_range(65535));
    endfunction

    // ------------------------------------------------------------------
    // Input side. Offer one word and wait for the handshake. Valid stays
    // high after acceptance unless a gap follows, so back-to-back words
    // flow without a bubble; drop_input() lowers it before any pause.
    // ------------------------------------------------------------------
    task automatic send_word(stsr_pkg::stsr_cmd_t cmd, time_word_t t);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        s_axis_tuser  <= cmd;
        do @(posedge aclk); while (!s_axis_tready);
        forecast_answer(cmd, t);
        if ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_gap_pct);
        end
    endtask

    task automatic drop_input();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_for_answers();
        while (pending_answers.size() != 0)
            @(posedge aclk);
    endtask

    // Write the window only with the block idle: input dropped, every answer back
    task automatic write_window(window_word_t value);
        drop_input();
        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        window_model = value;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, plus a long hold-off whenever a test
    // bumps the ticket. The hold-off is counted here, in cycles.
    // ------------------------------------------------------------------
    int hold_off_served = 0;
    int hold_off_left   = 0;

    always @(posedge aclk) begin
        if (hold_off_ticket != hold_off_served) begin
            hold_off_served <= hold_off_ticket;
            hold_off_left   <= HOLD_OFF_CYCLES;
            m_axis_tready   <= 1'b0;
        end else if (hold_off_left != 0) begin
            hold_off_left   <= hold_off_left - 1;
            m_axis_tready   <= 1'b0;
        end else begin
            m_axis_tready   <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(string detail);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $realtime, detail);
    endtask

    // Compare every accepted result word with the oldest answer waiting
    slot_answer_t want;

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("result word with nothing pending: status %0d count %0d",
                                          m_axis_tuser, m_axis_tdata));
            end else begin
                want = pending_answers.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch($sformatf("status expected %0d, got %0d",
                                              want.status, m_axis_tuser));
                if (m_axis_tdata !== {1'b0, want.count})
                    report_mismatch($sformatf("count expected %0d, got %0d",
                                              want.count, m_axis_tdata));
            end
        end
    end

    // Watchdog: end the run if neither side moves a word for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("spaced_time_slot_reserver test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table counts, then the reset window of three: duplicates and
    // near neighbors refused, exact spacing accepted, both ends of the range.
    task automatic test_empty_table_and_spacing();
        send_word(stsr_pkg::CMD_COUNT,   16'd0);
        send_word(stsr_pkg::CMD_COUNT,   16'hFFFF);
        send_word(stsr_pkg::CMD_RESERVE, 16'd100);
        send_word(stsr_pkg::CMD_RESERVE, 16'd100);
        send_word(stsr_pkg::CMD_RESERVE, 16'd102);
        send_word(stsr_pkg::CMD_RESERVE, 16'd103);
        send_word(stsr_pkg::CMD_RESERVE, 16'd97);
        send_word(stsr_pkg::CMD_RESERVE, 16'd98);
        send_word(stsr_pkg::CMD_RESERVE, 16'd0);
        send_word(stsr_pkg::CMD_RESERVE, 16'hFFFF);
        send_word(stsr_pkg::CMD_RESERVE, 16'hFFFD);
        send_word(stsr_pkg::CMD_COUNT,   16'd99);
        send_word(stsr_pkg::CMD_COUNT,   16'd100);
        send_word(stsr_pkg::CMD_COUNT,   16'hFFFE);
        send_word(stsr_pkg::CMD_COUNT,   16'hFFFF);
        send_word(stsr_pkg::CMD_COUNT,   16'd0);
    endtask

    // Window of zero lets duplicates in; then the widest window and a window of one
    task automatic test_window_extremes();
        write_window(8'd0);
        send_word(stsr_pkg::CMD_RESERVE, 16'd100);
        send_word(stsr_pkg::CMD_COUNT,   16'd100);
        write_window(8'd255);
        send_word(stsr_pkg::CMD_RESERVE, 16'd355);
        send_word(stsr_pkg::CMD_RESERVE, 16'd358);
        send_word(stsr_pkg::CMD_RESERVE, 16'd612);
        send_word(stsr_pkg::CMD_RESERVE, 16'd613);
        write_window(8'd1);
        send_word(stsr_pkg::CMD_RESERVE, 16'd614);
        send_word(stsr_pkg::CMD_RESERVE, 16'd613);
        send_word(stsr_pkg::CMD_COUNT,   16'd613);
    endtask

    task automatic test_random_traffic(int words, int reserve_pct, window_word_t window);
        stsr_pkg::stsr_cmd_t cmd;
        write_window(window);
        for (int i = 0; i < words; i++) begin
            if ($urandom_range(99) < reserve_pct)
                cmd = stsr_pkg::CMD_RESERVE;
            else
                cmd = stsr_pkg::CMD_COUNT;
            send_word(cmd, pick_time());
        end
    endtask

    // Stall the result side for a long stretch while words keep coming,
    // so the block backs up and holds off its input.
    task automatic test_output_backpressure();
        stsr_pkg::stsr_cmd_t cmd;
        hold_off_ticket <= hold_off_ticket + 1;
        for (int i = 0; i < 40; i++) begin
            if ($urandom_range(3) == 0)
                cmd = stsr_pkg::CMD_RESERVE;
            else
                cmd = stsr_pkg::CMD_COUNT;
            send_word(cmd, pick_time());
        end
    endtask

    // Fill the table, then show that a clash still reports conflict when full
    // and a clear time reports full.
    task automatic test_full_table();
        write_window(8'd1);
        for (int guard = 0; guard < 4 * SLOTS && booked_times.size() < SLOTS; guard++)
            send_word(stsr_pkg::CMD_RESERVE, time_word_t'($urandom_range(65535)));
        send_word(stsr_pkg::CMD_RESERVE, booked_times[0]);
        for (int i = 0; i < 3; i++)
            send_word(stsr_pkg::CMD_RESERVE, time_word_t'($urandom_range(65535)));
        send_word(stsr_pkg::CMD_COUNT, 16'hFFFF);
        write_window(8'd255);
        for (int i = 0; i < 6; i++)
            send_word(stsr_pkg::CMD_RESERVE, pick_time());
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender gaps light, receiver stalls heavy
        send_gap_pct   = 19;
        recv_stall_pct = 57;
        test_empty_table_and_spacing();
        test_window_extremes();
        test_random_traffic(350, 20, 8'd40);

        // the other way round
        send_gap_pct   = 57;
        recv_stall_pct = 19;
        test_random_traffic(350, 20, 8'd200);

        // no idling from here on
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_output_backpressure();
        test_full_table();
        for (int phase = 0; phase < 4; phase++)
            test_random_traffic(85, 30, window_word_t'($urandom_range(255, 1)));

        drop_input();
        wait_for_answers();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_answers.size() == 0)
            $display("spaced_time_slot_reserver test passed");
        else
            $display("spaced_time_slot_reserver test failed");
        $finish;
    end

endmodule
